@@ hdl/vwi_pkg.sv @@
// Shared types, constants and float compare helper for the vertex weld indexer.
package vwi_pkg;

	localparam int unsigned DefMaxUnique  = 1024;
	localparam int unsigned DefTableSlots = 2048;
	localparam logic [31:0] HashMul       = 32'h9E3779B1;
	localparam int unsigned IdxOutW       = 10;

	typedef struct packed {
		logic        start_layer;
		logic [31:0] x_bits;
		logic [31:0] y_bits;
		logic [31:0] z_bits;
	} vert_item_t;

	typedef struct packed {
		logic [IdxOutW-1:0] vertex_index;
		logic               is_new;
		logic [1:0]         corner;
		logic               triangle_dropped;
		logic               table_overflow;
		logic [31:0]        box_lo_x;
		logic [31:0]        box_lo_y;
		logic [31:0]        box_lo_z;
		logic [31:0]        box_hi_x;
		logic [31:0]        box_hi_y;
		logic [31:0]        box_hi_z;
	} result_item_t;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic mult;
		logic mod_step;
		logic slot_load;
		logic probe;
		logic advance;
		logic insert;
		logic hit;
		logic overflow;
		logic out_load;
	} vwi_cmd_t;

	typedef struct packed {
		logic start;
		logic clr_last;
		logic mod_done;
		logic empty;
		logic match;
		logic probe_last;
		logic room;
		logic out_free;
	} vwi_stat_t;

	function automatic logic is_nan32(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	// IEEE a < b on float32 bit patterns; NaN compares false, signed zeros equal.
	function automatic logic less32(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ka;
		logic [31:0] kb;
		ka = a[31] ? ~a : (a | 32'h8000_0000);
		kb = b[31] ? ~b : (b | 32'h8000_0000);
		if (is_nan32(a) || is_nan32(b)) begin
			return 1'b0;
		end
		if (((a | b) & 32'h7FFF_FFFF) == 32'd0) begin
			return 1'b0;
		end
		return ka < kb;
	endfunction

endpackage

@@ hdl/vwi_ram.sv @@
// Generic single-port-write, registered-read RAM.
module vwi_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/vwi_ctrl.sv @@
// Controller state machine for the vertex weld indexer.
module vwi_ctrl import vwi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      vert_valid,
	output logic      vert_ready,
	input  vwi_stat_t stat,
	output vwi_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_HASH  = 7'b0000100,
		ST_MOD   = 7'b0001000,
		ST_PROBE = 7'b0010000,
		ST_CHECK = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   busy_q, busy_d;

	assign vert_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		busy_d  = busy_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = busy_q ? ST_HASH : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (vert_valid) begin
					cmd.load = 1'b1;
					busy_d   = 1'b1;
					state_d  = stat.start ? ST_CLEAR : ST_HASH;
				end
			end
			ST_HASH: begin
				cmd.mult = 1'b1;
				state_d  = ST_MOD;
			end
			ST_MOD: begin
				if (stat.mod_done) begin
					cmd.slot_load = 1'b1;
					state_d       = ST_PROBE;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = ST_DONE;
				priority if (stat.empty) begin
					if (stat.room) begin
						cmd.insert = 1'b1;
					end else begin
						cmd.overflow = 1'b1;
					end
				end else if (stat.match) begin
					cmd.hit = 1'b1;
				end else if (stat.probe_last) begin
					cmd.overflow = 1'b1;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_PROBE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					busy_d       = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				busy_d  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= busy_d;
		end
	end

endmodule

@@ hdl/vwi_dp.sv @@
// Datapath: hash, slot table, triangle tracking, bounding box and output register.
module vwi_dp import vwi_pkg::*; #(
	parameter int unsigned MAX_UNIQUE  = DefMaxUnique,
	parameter int unsigned TABLE_SLOTS = DefTableSlots
) (
	input  logic         clk,
	input  logic         arst_n,
	input  vert_item_t   vert,
	input  vwi_cmd_t     cmd,
	output vwi_stat_t    stat,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result
);

	localparam int unsigned SW    = $clog2(TABLE_SLOTS);
	localparam int unsigned IW    = $clog2(MAX_UNIQUE);
	localparam int unsigned CW    = $clog2(MAX_UNIQUE + 1);
	localparam int unsigned WW    = 1 + 96 + IW;
	localparam bit          Pow2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
	localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

	logic [31:0]   x_q, y_q, z_q;
	logic [31:0]   h0_q, hm_q;
	logic [5:0]    mcnt_q;
	logic [31:0]   q_q, qn_q;
	logic [SW-1:0] slot_q, n_q, clr_addr_q;
	logic [CW-1:0] ucnt_q;
	logic [1:0]    corner_q;
	logic [IW-1:0] ha_q, hb_q;
	logic          ha_ov_q, hb_ov_q, bad_q;
	logic [31:0]   box_q [6];
	logic [IW-1:0] res_idx_q;
	logic          res_new_q, res_ovf_q, res_drop_q;
	logic [1:0]    res_corner_q;
	logic          outv_q;
	result_item_t  out_q;

	logic [WW-1:0] rdata, wdata;
	logic [SW-1:0] waddr;
	logic          we;

	logic [31:0]   hv;
	logic [63:0]   prod;
	logic [31:0]   rem;
	logic [SW-1:0] slot_c;
	logic [IW-1:0] idx_c;
	logic          fin, eq_a, eq_b, eq_ab, bad_n;

	// The quotient estimate from the reciprocal is low by at most one, so a
	// single compare and subtract finishes the remainder.
	assign hv     = hm_q ^ (hm_q >> 15);
	assign prod   = 64'(hv) * 64'(Recip);
	assign rem    = hv - qn_q;
	assign slot_c = Pow2 ? hv[SW-1:0] :
		((rem >= 32'(TABLE_SLOTS)) ? SW'(rem - 32'(TABLE_SLOTS)) : SW'(rem));

	assign we    = cmd.clr_step | cmd.insert;
	assign waddr = cmd.clr_step ? clr_addr_q : slot_q;
	assign wdata = cmd.clr_step ? '0 : {1'b1, z_q, y_q, x_q, IW'(ucnt_q)};

	vwi_ram #(.WIDTH(WW), .DEPTH(TABLE_SLOTS)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.probe),
		.raddr (slot_q),
		.rdata (rdata)
	);

	assign stat.start      = vert.start_layer;
	assign stat.clr_last   = clr_addr_q == SW'(TABLE_SLOTS - 1);
	assign stat.mod_done   = Pow2 ? 1'b1 : (mcnt_q == 6'd2);
	assign stat.empty      = !rdata[WW-1];
	assign stat.match      = rdata[WW-2:IW] == {z_q, y_q, x_q};
	assign stat.probe_last = n_q == SW'(TABLE_SLOTS - 1);
	assign stat.room       = ucnt_q < CW'(MAX_UNIQUE);
	assign stat.out_free   = !outv_q || result_ready;

	assign fin   = cmd.insert | cmd.hit | cmd.overflow;
	assign idx_c = cmd.insert ? IW'(ucnt_q) : (cmd.hit ? rdata[IW-1:0] : '0);
	assign eq_a  = !ha_ov_q && (ha_q == idx_c);
	assign eq_b  = !hb_ov_q && (hb_q == idx_c);
	assign eq_ab = !ha_ov_q && !hb_ov_q && (ha_q == hb_q);
	assign bad_n = bad_q | cmd.overflow |
		(!cmd.overflow && corner_q == 2'd1 && eq_a) |
		(!cmd.overflow && corner_q == 2'd2 && (eq_a || eq_b || eq_ab));

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= vert.x_bits;
			y_q     <= vert.y_bits;
			z_q     <= vert.z_bits;
			h0_q    <= vert.x_bits ^ {vert.y_bits[30:0], vert.y_bits[31]} ^
				{vert.z_bits[29:0], vert.z_bits[31:30]};
		end
		if (cmd.mult) begin
			hm_q <= 32'(h0_q * HashMul);
		end
		if (cmd.mod_step) begin
			q_q  <= prod[63:32];
			qn_q <= 32'(q_q * 32'(TABLE_SLOTS));
		end
		if (cmd.slot_load) begin
			slot_q <= slot_c;
			n_q    <= '0;
		end else if (cmd.advance) begin
			slot_q <= (slot_q == SW'(TABLE_SLOTS - 1)) ? '0 : slot_q + 1'b1;
			n_q    <= n_q + 1'b1;
		end
		if (fin) begin
			res_idx_q    <= idx_c;
			res_new_q    <= cmd.insert;
			res_ovf_q    <= cmd.overflow;
			res_corner_q <= corner_q;
			res_drop_q   <= (corner_q == 2'd2) && bad_n;
		end
		if (cmd.out_load) begin
			out_q.vertex_index     <= IdxOutW'(res_idx_q);
			out_q.is_new           <= res_new_q;
			out_q.corner           <= res_corner_q;
			out_q.triangle_dropped <= res_drop_q;
			out_q.table_overflow   <= res_ovf_q;
			out_q.box_lo_x         <= box_q[0];
			out_q.box_lo_y         <= box_q[1];
			out_q.box_lo_z         <= box_q[2];
			out_q.box_hi_x         <= box_q[3];
			out_q.box_hi_y         <= box_q[4];
			out_q.box_hi_z         <= box_q[5];
		end
	end

	// Control and running state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q     <= '0;
			clr_addr_q <= '0;
			ucnt_q     <= '0;
			corner_q   <= '0;
			ha_q       <= '0;
			hb_q       <= '0;
			ha_ov_q    <= 1'b0;
			hb_ov_q    <= 1'b0;
			bad_q      <= 1'b0;
			outv_q     <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				box_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				mcnt_q <= '0;
			end else if (cmd.mod_step) begin
				mcnt_q <= mcnt_q + 1'b1;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= stat.clr_last ? '0 : clr_addr_q + 1'b1;
			end
			if (cmd.load && vert.start_layer) begin
				ucnt_q   <= '0;
				corner_q <= '0;
				ha_q     <= '0;
				hb_q     <= '0;
				ha_ov_q  <= 1'b0;
				hb_ov_q  <= 1'b0;
				bad_q    <= 1'b0;
				for (int i = 0; i < 6; i++) begin
					box_q[i] <= '0;
				end
			end
			if (cmd.insert) begin
				ucnt_q <= ucnt_q + 1'b1;
				for (int i = 0; i < 3; i++) begin
					logic [31:0] p;
					p = (i == 0) ? x_q : ((i == 1) ? y_q : z_q);
					if (ucnt_q == '0) begin
						box_q[i]     <= p;
						box_q[i + 3] <= p;
					end else begin
						if (less32(p, box_q[i])) begin
							box_q[i] <= p;
						end
						if (less32(box_q[i + 3], p)) begin
							box_q[i + 3] <= p;
						end
					end
				end
			end
			if (fin) begin
				if (corner_q == 2'd0) begin
					ha_q    <= idx_c;
					ha_ov_q <= cmd.overflow;
				end
				if (corner_q == 2'd1) begin
					hb_q    <= idx_c;
					hb_ov_q <= cmd.overflow;
				end
				if (corner_q == 2'd2) begin
					corner_q <= '0;
					bad_q    <= 1'b0;
				end else begin
					corner_q <= corner_q + 1'b1;
					bad_q    <= bad_n;
				end
			end
			if (cmd.out_load) begin
				outv_q <= 1'b1;
			end else if (result_ready) begin
				outv_q <= 1'b0;
			end
		end
	end

	assign result_valid = outv_q;
	assign result       = out_q;

endmodule

@@ hdl/vertex_weld_indexer.sv @@
// Top level of the vertex weld indexer: controller, datapath and checks.
//
// Usage: vertices arrive on the vert channel (valid/ready), one item per
// vertex with a start flag and three float32 bit patterns. Each item yields
// exactly one result item on the result channel (valid/ready) carrying the
// welded index, new/overflow flags, corner, triangle drop flag and the box.
// Steps: after acceptance the controller hashes the position (HASH),
// reduces it to a slot (MOD, with a reciprocal slot reduction when
// TABLE_SLOTS is not a power of two), reads and checks table slots in
// turn (PROBE, CHECK) until an empty slot, a match or the end of the
// table, and loads the result (DONE). An item with the start flag set
// first sweeps the table. The controller takes the next item only after
// the result is loaded, so it cannot accept a vertex while one is in work.
// After reset the block sweeps the table with ready low. The result sits
// in an output register; while the receiver stalls, the next item is
// accepted and worked on, and it waits for the register.
module vertex_weld_indexer import vwi_pkg::*; #(
	parameter int unsigned MAX_UNIQUE  = DefMaxUnique,
	parameter int unsigned TABLE_SLOTS = DefTableSlots
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         vert_valid,
	output logic         vert_ready,
	input  vert_item_t   vert,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result
);

	vwi_cmd_t  cmd;
	vwi_stat_t stat;

	vwi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.vert_valid (vert_valid),
		.vert_ready (vert_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	vwi_dp #(.MAX_UNIQUE(MAX_UNIQUE), .TABLE_SLOTS(TABLE_SLOTS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.vert         (vert),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_corner_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.corner != 2'd3)
		else $error("corner out of range");

	a_new_xor_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.is_new && result.table_overflow))
		else $error("new and overflow together");

	a_drop_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.corner != 2'd2) |-> !result.triangle_dropped)
		else $error("drop flag before closing corner");

	a_ovf_index: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.table_overflow) |->
		(result.vertex_index == '0 && result.corner == 2'd2 ?
			result.triangle_dropped : result.vertex_index == '0))
		else $error("overflowed item with nonzero index or kept triangle");

endmodule

@@ sim/vertex_weld_indexer_tb.sv @@
// Self-checking testbench for the vertex weld indexer: directed and random vertices.
module vertex_weld_indexer_tb import vwi_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS      = DefTableSlots;
	localparam int unsigned UNIQUE_CAP = DefMaxUnique;
	localparam int unsigned CYCLE_CAP  = 900_000;
	localparam int unsigned FILL_N     = 300;
	localparam int unsigned RANDOM_N   = 330;
	localparam int unsigned POOL_N     = 24;
	localparam logic [31:0] PZERO      = 32'h0000_0000;
	localparam logic [31:0] NZERO      = 32'h8000_0000;
	localparam logic [31:0] PINF       = 32'h7F80_0000;
	localparam logic [31:0] NINF       = 32'hFF80_0000;
	localparam logic [31:0] QNAN       = 32'h7FC0_0000;
	localparam logic [31:0] PMAX       = 32'h7F7F_FFFF;
	localparam logic [31:0] NMAX       = 32'hFF7F_FFFF;
	localparam logic [31:0] ONE        = 32'h3F80_0000;

	logic         clk;
	logic         arst_n;
	logic         vert_valid;
	logic         vert_ready;
	vert_item_t   vert;
	logic         result_valid;
	logic         result_ready = 1'b0;
	result_item_t result;

	vertex_weld_indexer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.vert_valid   (vert_valid),
		.vert_ready   (vert_ready),
		.vert         (vert),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Shadow copy of the weld table and triangle state.
	bit           slot_used [SLOTS];
	logic [95:0]  slot_pos  [SLOTS];
	logic [9:0]   slot_idx  [SLOTS];
	int unsigned  welded_count;
	int unsigned  corner_pos;
	logic [31:0]  first_idx;
	logic [31:0]  second_idx;
	bit           tri_bad;
	logic [31:0]  bounds [6];

	result_item_t pending_results [$];
	int unsigned  cycle_count = 0;
	int unsigned  error_count = 0;
	bit           calm;
	bit           hold_request;
	logic [95:0]  pos_pool [POOL_N];

	typedef struct {
		vert_item_t   item;
		bit           typed;
		result_item_t want;
	} stim_row_t;

	stim_row_t directed [$];

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic float_is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic float_below(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] oa;
		logic [31:0] ob;
		if (float_is_nan(a) || float_is_nan(b)) begin
			return 1'b0;
		end
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
			return 1'b0;
		end
		// Map to an order that unsigned compare respects.
		oa = a[31] ? ~a : {1'b1, a[30:0]};
		ob = b[31] ? ~b : {1'b1, b[30:0]};
		return oa < ob;
	endfunction

	function automatic logic [10:0] slot_hash(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		logic [31:0] h;
		h = x ^ {y[30:0], y[31]} ^ {z[29:0], z[31:30]};
		h = h * HashMul;
		h = h ^ (h >> 15);
		return h[10:0];
	endfunction

	function automatic void clear_weld_state();
		foreach (slot_used[i]) begin
			slot_used[i] = 1'b0;
		end
		foreach (bounds[i]) begin
			bounds[i] = 32'd0;
		end
		welded_count = 0;
		corner_pos   = 0;
		first_idx    = 32'd0;
		second_idx   = 32'd0;
		tri_bad      = 1'b0;
	endfunction

	function automatic result_item_t weld_vertex(input vert_item_t it);
		result_item_t r;
		logic [95:0]  key;
		logic [10:0]  s;
		logic [31:0]  p [3];
		logic [31:0]  idx;
		bit           hit;
		bit           free;
		bit           ovf;
		bit           fresh;
		if (it.start_layer) begin
			clear_weld_state();
		end
		p[0] = it.x_bits;
		p[1] = it.y_bits;
		p[2] = it.z_bits;
		key = {it.z_bits, it.y_bits, it.x_bits};
		s = slot_hash(it.x_bits, it.y_bits, it.z_bits);
		hit = 1'b0;
		free = 1'b0;
		idx = 32'd0;
		for (int n = 0; n < SLOTS; n++) begin
			if (!slot_used[s]) begin
				free = 1'b1;
				break;
			end
			if (slot_pos[s] == key) begin
				hit = 1'b1;
				idx = slot_idx[s];
				break;
			end
			s = s + 1'b1;
		end
		ovf = 1'b0;
		fresh = 1'b0;
		if (!hit) begin
			if (free && welded_count < UNIQUE_CAP) begin
				idx = welded_count;
				slot_used[s] = 1'b1;
				slot_pos[s] = key;
				slot_idx[s] = idx[9:0];
				for (int i = 0; i < 3; i++) begin
					if (welded_count == 0) begin
						bounds[i] = p[i];
						bounds[i + 3] = p[i];
					end else begin
						if (float_below(p[i], bounds[i])) begin
							bounds[i] = p[i];
						end
						if (float_below(bounds[i + 3], p[i])) begin
							bounds[i + 3] = p[i];
						end
					end
				end
				welded_count++;
				fresh = 1'b1;
			end else begin
				ovf = 1'b1;
			end
		end
		r = '0;
		r.corner = corner_pos[1:0];
		if (ovf) begin
			tri_bad = 1'b1;
			// An overflowed corner must never match another corner.
			if (corner_pos == 0) begin
				first_idx = 32'hFFFF_FFFF;
			end else if (corner_pos == 1) begin
				second_idx = 32'hFFFF_FFFE;
			end
		end else if (corner_pos == 0) begin
			first_idx = idx;
		end else if (corner_pos == 1) begin
			second_idx = idx;
			if (first_idx == idx) begin
				tri_bad = 1'b1;
			end
		end else if (first_idx == idx || second_idx == idx || first_idx == second_idx) begin
			tri_bad = 1'b1;
		end
		if (corner_pos == 2) begin
			r.triangle_dropped = tri_bad;
			tri_bad = 1'b0;
			corner_pos = 0;
		end else begin
			corner_pos++;
		end
		r.vertex_index   = idx[9:0];
		r.is_new         = fresh;
		r.table_overflow = ovf;
		r.box_lo_x = bounds[0];
		r.box_lo_y = bounds[1];
		r.box_lo_z = bounds[2];
		r.box_hi_x = bounds[3];
		r.box_hi_y = bounds[4];
		r.box_hi_z = bounds[5];
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] pick_coord();
		unique case ($urandom_range(0, 11))
			0: return PZERO;
			1: return NZERO;
			2: return PINF;
			3: return NINF;
			4: return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
			5: return ONE;
			6: return {1'($urandom_range(0, 1)), 8'h00, 23'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic void refill_pool();
		foreach (pos_pool[i]) begin
			pos_pool[i] = {pick_coord(), pick_coord(), pick_coord()};
		end
	endfunction

	task automatic send_vertex(input vert_item_t it, input bit typed, input result_item_t want);
		int unsigned gap;
		vert <= it;
		vert_valid <= 1'b1;
		do @(posedge clk); while (!vert_ready);
		if (typed) begin
			void'(weld_vertex(it));
			pending_results = {pending_results, want};
		end else begin
			pending_results = {pending_results, weld_vertex(it)};
		end
		gap = pick_gap();
		if (gap != 0) begin
			vert_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			error_count++;
		end
	endtask

	// Receiver: short random stalls, calm stretches, and one long hold-off on request.
	int unsigned stall_left = 0;
	bit          hold_done = 1'b0;
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if (hold_request && !hold_done) begin
			hold_done <= 1'b1;
			stall_left <= 500;
			result_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= pick_gap();
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with no expectation waiting");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("vertex_index", 32'(want.vertex_index),
					32'(result.vertex_index));
				check_field("is_new", 32'(want.is_new), 32'(result.is_new));
				check_field("corner", 32'(want.corner), 32'(result.corner));
				check_field("triangle_dropped", 32'(want.triangle_dropped),
					32'(result.triangle_dropped));
				check_field("table_overflow", 32'(want.table_overflow),
					32'(result.table_overflow));
				check_field("box_lo_x", want.box_lo_x, result.box_lo_x);
				check_field("box_lo_y", want.box_lo_y, result.box_lo_y);
				check_field("box_lo_z", want.box_lo_z, result.box_lo_z);
				check_field("box_hi_x", want.box_hi_x, result.box_hi_x);
				check_field("box_hi_y", want.box_hi_y, result.box_hi_y);
				check_field("box_hi_z", want.box_hi_z, result.box_hi_z);
			end
		end
	end

	function automatic void add_row(input logic st, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input bit typed, input result_item_t want);
		stim_row_t row;
		row.item  = '{start_layer: st, x_bits: x, y_bits: y, z_bits: z};
		row.typed = typed;
		row.want  = want;
		directed = {directed, row};
	endfunction

	function automatic result_item_t zero_box(input logic [9:0] idx, input logic fresh,
			input logic [1:0] c, input logic drop);
		result_item_t r;
		r = '0;
		r.vertex_index = idx;
		r.is_new = fresh;
		r.corner = c;
		r.triangle_dropped = drop;
		return r;
	endfunction

	initial begin
		vert_item_t   it;
		result_item_t none;
		result_item_t seeded;
		logic [95:0]  p;
		logic [95:0]  keep;
		none = '0;
		arst_n = 1'b0;
		vert_valid = 1'b0;
		vert = '0;
		hold_request = 1'b0;
		calm = 1'b0;
		clear_weld_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Signed zeros are distinct keys but the box treats them as equal.
		add_row(1'b0, PZERO, PZERO, PZERO, 1'b1, zero_box(10'd0, 1'b1, 2'd0, 1'b0));
		add_row(1'b0, NZERO, PZERO, PZERO, 1'b1, zero_box(10'd1, 1'b1, 2'd1, 1'b0));
		add_row(1'b0, PZERO, PZERO, PZERO, 1'b1, zero_box(10'd0, 1'b0, 2'd2, 1'b1));
		// The first stored position after a clear seeds the box with itself.
		seeded = '0;
		seeded.is_new = 1'b1;
		seeded.box_lo_x = QNAN;
		seeded.box_lo_y = PINF;
		seeded.box_lo_z = NINF;
		seeded.box_hi_x = QNAN;
		seeded.box_hi_y = PINF;
		seeded.box_hi_z = NINF;
		add_row(1'b1, QNAN, PINF, NINF, 1'b1, seeded);
		add_row(1'b0, 32'h7FC0_0001, ONE, NMAX, 1'b0, none);
		add_row(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none);
		add_row(1'b0, PMAX, NMAX, PMAX, 1'b0, none);
		add_row(1'b0, NMAX, PMAX, 32'h0000_0001, 1'b0, none);
		add_row(1'b0, PMAX, NMAX, PMAX, 1'b0, none);
		add_row(1'b0, ONE, ONE, ONE, 1'b0, none);
		add_row(1'b0, ONE, ONE, ONE, 1'b0, none);
		// A clear in the middle of a triangle restarts the corner count, so the partial triangle is never flagged.
		add_row(1'b1, ONE, PZERO, NZERO, 1'b0, none);
		add_row(1'b0, 32'h8000_0001, PINF, NINF, 1'b0, none);
		add_row(1'b0, NINF, 32'hFFFF_FFFF, PINF, 1'b0, none);
		add_row(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none);
		add_row(1'b0, ONE, PZERO, NZERO, 1'b0, none);
		add_row(1'b0, ONE, PZERO, NZERO, 1'b0, none);
		foreach (directed[i]) begin
			send_vertex(directed[i].item, directed[i].typed, directed[i].want);
		end

		// Load many distinct positions so that probe chains build up.
		p = {$urandom, $urandom, $urandom};
		keep = p;
		for (int i = 0; i < FILL_N; i++) begin
			it = '{start_layer: (i == 0), x_bits: p[31:0], y_bits: p[63:32], z_bits: p[95:64]};
			send_vertex(it, 1'b0, none);
			p = {$urandom, $urandom, $urandom};
		end
		for (int i = 0; i < 4; i++) begin
			it = '{start_layer: 1'b0, x_bits: keep[31:0], y_bits: keep[63:32],
				z_bits: keep[95:64]};
			send_vertex(it, 1'b0, none);
		end
		it = '{start_layer: 1'b0, x_bits: $urandom, y_bits: $urandom, z_bits: $urandom};
		send_vertex(it, 1'b0, none);

		refill_pool();
		for (int i = 0; i < RANDOM_N; i++) begin
			if (i % 64 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			if (i == 100) begin
				hold_request = 1'b1;
			end
			if (i == 250) begin
				vert_valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
			if ($urandom_range(0, 9) < 6) begin
				p = pos_pool[$urandom_range(0, POOL_N - 1)];
			end else begin
				p = {pick_coord(), pick_coord(), pick_coord()};
			end
			it.start_layer = ($urandom_range(0, 79) == 0);
			if (it.start_layer) begin
				refill_pool();
			end
			it.x_bits = p[31:0];
			it.y_bits = p[63:32];
			it.z_bits = p[95:64];
			send_vertex(it, 1'b0, none);
		end
		vert_valid <= 1'b0;
		calm = 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/vwi_pkg.sv
hdl/vwi_ram.sv
hdl/vwi_ctrl.sv
hdl/vwi_dp.sv
hdl/vertex_weld_indexer.sv
sim/vertex_weld_indexer_tb.sv
